>>> hw/rtl/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types and constants for the array-based doubly linked list core.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int CAPACITY = 1024;
  localparam int NSLOTS   = CAPACITY + 2;
  localparam int NVALUES  = 1024;
  localparam int VAL_W    = 10;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = $clog2(NSLOTS);
  localparam int FREE_W   = $clog2(NSLOTS + 1);

  localparam logic [KIND_W-1:0] KIND_INS_LEFT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_RIGHT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_END    = 3'd4;

  localparam logic [SLOT_W-1:0] HEAD_SLOT  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] TAIL_SLOT  = SLOT_W'(1);
  localparam logic [FREE_W-1:0] FIRST_DATA = FREE_W'(2);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  anchor_value;
    logic [VAL_W-1:0]  new_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
  } out_item_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } map_ent_t;

  typedef struct packed {
    logic             en;
    logic [VAL_W-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic             en;
    logic [VAL_W-1:0] addr;
    map_ent_t         data;
  } map_wr_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] left;
    logic [SLOT_W-1:0] right;
  } node_ent_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } node_rd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] addr;
    logic              en_val;
    logic              en_left;
    logic              en_right;
    node_ent_t         data;
  } node_wr_t;

endpackage

>>> hw/rtl/adll_map_mem.sv
// ----------------------------------------------------------------------------
// adll_map_mem
// Value map: per value a present flag and the slot holding it.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module adll_map_mem (
  input  logic              clk,
  input  adll_pkg::map_rd_t rd,
  input  adll_pkg::map_wr_t wr,
  output adll_pkg::map_ent_t rdata
);
  import adll_pkg::*;

  map_ent_t mem [NVALUES];
  map_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/adll_node_mem.sv
// ----------------------------------------------------------------------------
// adll_node_mem
// Node store: value, left link and right link per slot, with a write
// enable per field. One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module adll_node_mem (
  input  logic                clk,
  input  adll_pkg::node_rd_t  rd,
  input  adll_pkg::node_wr_t  wr,
  output adll_pkg::node_ent_t rdata
);
  import adll_pkg::*;

  logic [VAL_W-1:0]  val_mem   [NSLOTS];
  logic [SLOT_W-1:0] left_mem  [NSLOTS];
  logic [SLOT_W-1:0] right_mem [NSLOTS];
  node_ent_t         rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en_val) begin
      val_mem[wr.addr] <= wr.data.value;
    end
    if (wr.en_left) begin
      left_mem[wr.addr] <= wr.data.left;
    end
    if (wr.en_right) begin
      right_mem[wr.addr] <= wr.data.right;
    end
    if (rd.en) begin
      rdata_r.value <= val_mem[rd.addr];
      rdata_r.left  <= left_mem[rd.addr];
      rdata_r.right <= right_mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/array_doubly_linked_list_core.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list_core
// Doubly linked list of 10-bit values held in a node store, with slot 0 as
// head sentinel and slot 1 as tail sentinel, plus a value map to find
// anchors by value. One operation per input transfer, one result per
// operation. After reset the block runs a clearing pass over the value
// map (and sentinel slots) before it takes its first transfer. Operations
// are handled one at a time: both stores have one write port, one read
// port and registered read data, and each operation is a chain of
// dependent reads and writes on them. Failed operations and unused kinds
// end after the map lookups; the others go on to the node store. The
// result sits in an output register, so a stalled result does not block
// the next input transfer; a following result waits for it.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adll_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adll_pkg::out_item_t out_data
);
  import adll_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RDX, S_CHK, S_NODE, S_W1, S_W2, S_VAL
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [VAL_W-1:0]  a_r, a_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt;
  map_ent_t          ent_a_r, ent_a_nxt;
  logic [SLOT_W-1:0] p_r, p_nxt;
  logic [SLOT_W-1:0] q_r, q_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [SLOT_W-1:0] cursor_r, cursor_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  map_rd_t   map_rd;
  map_wr_t   map_wr;
  map_ent_t  map_rdata;
  node_rd_t  node_rd;
  node_wr_t  node_wr;
  node_ent_t node_rdata;

  logic              accept;
  logic              out_free;
  logic              full;
  logic [SLOT_W-1:0] new_slot;
  logic              fin;
  logic [STAT_W-1:0] fin_st;
  logic [VAL_W-1:0]  fin_val;

  adll_map_mem u_map (
    .clk   (clk),
    .rd    (map_rd),
    .wr    (map_wr),
    .rdata (map_rdata)
  );

  adll_node_mem u_node (
    .clk   (clk),
    .rd    (node_rd),
    .wr    (node_wr),
    .rdata (node_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (free_r >= FREE_W'(NSLOTS));
  assign new_slot  = free_r[SLOT_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    x_nxt         = x_r;
    ent_a_nxt     = ent_a_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    free_nxt      = free_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    map_rd        = '0;
    map_wr        = '0;
    node_rd       = '0;
    node_wr       = '0;
    fin           = 1'b0;
    fin_st        = ST_OK;
    fin_val       = '0;

    case (state_r)
      S_CLR: begin
        map_wr.en           = 1'b1;
        map_wr.addr         = clr_cnt_r;
        node_wr.addr        = SLOT_W'(clr_cnt_r);
        node_wr.en_val      = 1'b1;
        node_wr.en_left     = 1'b1;
        node_wr.en_right    = 1'b1;
        node_wr.data.left   = HEAD_SLOT;
        node_wr.data.right  = TAIL_SLOT;
        clr_cnt_nxt         = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        map_rd.en   = 1'b1;
        map_rd.addr = in_data.anchor_value;
        if (accept) begin
          kind_nxt  = in_data.kind;
          a_nxt     = in_data.anchor_value;
          x_nxt     = in_data.new_value;
          state_nxt = S_RDX;
        end
      end
      S_RDX: begin
        ent_a_nxt   = map_rdata;
        map_rd.en   = 1'b1;
        map_rd.addr = x_r;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        // map_rdata now holds the entry of the new value
        case (kind_r)
          KIND_INS_LEFT, KIND_INS_RIGHT: begin
            if (!ent_a_r.present) begin
              fin = 1'b1; fin_st = ST_ABSENT;
            end else if (map_rdata.present) begin
              fin = 1'b1; fin_st = ST_DUP;
            end else if (full) begin
              fin = 1'b1; fin_st = ST_FULL;
            end else begin
              node_rd   = '{en: 1'b1, addr: ent_a_r.slot};
              state_nxt = S_NODE;
            end
          end
          KIND_REMOVE: begin
            if (!ent_a_r.present) begin
              fin = 1'b1; fin_st = ST_ABSENT;
            end else begin
              node_rd   = '{en: 1'b1, addr: ent_a_r.slot};
              state_nxt = S_NODE;
            end
          end
          KIND_READ_FIRST: begin
            node_rd   = '{en: 1'b1, addr: HEAD_SLOT};
            state_nxt = S_NODE;
          end
          KIND_READ_NEXT: begin
            node_rd   = '{en: 1'b1, addr: cursor_r};
            state_nxt = S_NODE;
          end
          KIND_PUSH_FRONT: begin
            if (map_rdata.present) begin
              fin = 1'b1; fin_st = ST_DUP;
            end else if (full) begin
              fin = 1'b1; fin_st = ST_FULL;
            end else begin
              node_rd   = '{en: 1'b1, addr: HEAD_SLOT};
              state_nxt = S_NODE;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_NODE: begin
        case (kind_r)
          KIND_INS_LEFT, KIND_INS_RIGHT, KIND_PUSH_FRONT: begin
            // new node goes between p and q; for insert-left q is the anchor
            if (kind_r == KIND_INS_RIGHT) begin
              p_nxt = ent_a_r.slot;
              q_nxt = node_rdata.right;
            end else if (kind_r == KIND_INS_LEFT) begin
              p_nxt = node_rdata.left;
              q_nxt = ent_a_r.slot;
            end else begin
              p_nxt = HEAD_SLOT;
              q_nxt = node_rdata.right;
            end
            node_wr.addr       = new_slot;
            node_wr.en_val     = 1'b1;
            node_wr.en_left    = 1'b1;
            node_wr.en_right   = 1'b1;
            node_wr.data.value = x_r;
            node_wr.data.left  = p_nxt;
            node_wr.data.right = q_nxt;
            state_nxt          = S_W1;
          end
          KIND_REMOVE: begin
            p_nxt              = node_rdata.left;
            q_nxt              = node_rdata.right;
            node_wr.addr       = node_rdata.left;
            node_wr.en_right   = 1'b1;
            node_wr.data.right = node_rdata.right;
            map_wr.en          = 1'b1;
            map_wr.addr        = a_r;
            map_wr.data        = '{present: 1'b0, slot: ent_a_r.slot};
            state_nxt          = S_W1;
          end
          KIND_READ_FIRST, KIND_READ_NEXT: begin
            if (node_rdata.right == TAIL_SLOT) begin
              fin    = 1'b1;
              fin_st = ST_END;
              if (kind_r == KIND_READ_FIRST) begin
                cursor_nxt = HEAD_SLOT;
              end
            end else begin
              q_nxt     = node_rdata.right;
              node_rd   = '{en: 1'b1, addr: node_rdata.right};
              state_nxt = S_VAL;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_W1: begin
        node_wr.addr    = q_r;
        node_wr.en_left = 1'b1;
        if (kind_r == KIND_REMOVE) begin
          node_wr.data.left = p_r;
          fin               = 1'b1;
          if (cursor_r == ent_a_r.slot) begin
            cursor_nxt = p_r;
          end
        end else begin
          node_wr.data.left = new_slot;
          state_nxt         = S_W2;
        end
      end
      S_W2: begin
        node_wr.addr       = p_r;
        node_wr.en_right   = 1'b1;
        node_wr.data.right = new_slot;
        map_wr.en          = 1'b1;
        map_wr.addr        = x_r;
        map_wr.data        = '{present: 1'b1, slot: new_slot};
        free_nxt           = free_r + 1'b1;
        fin                = 1'b1;
      end
      S_VAL: begin
        fin        = 1'b1;
        fin_val    = node_rdata.value;
        cursor_nxt = q_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // finishing steps wait for the output register; their writes wait too
    if (fin && !out_free) begin
      state_nxt        = state_r;
      map_wr.en        = 1'b0;
      node_wr.en_val   = 1'b0;
      node_wr.en_left  = 1'b0;
      node_wr.en_right = 1'b0;
      free_nxt         = free_r;
      cursor_nxt       = cursor_r;
    end else if (fin) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_nxt       = '{status: fin_st, value_out: fin_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      free_r      <= FIRST_DATA;
      cursor_r    <= HEAD_SLOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_r      <= free_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    x_r     <= x_nxt;
    ent_a_r <= ent_a_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    out_r   <= out_nxt;
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(NSLOTS))
    else $error("free slot counter past the end of the node store");

  a_cursor_not_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r != TAIL_SLOT)
    else $error("read cursor sits on the tail sentinel");

  a_new_node_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (node_wr.en_val && state_r != S_CLR) |-> (node_wr.addr >= SLOT_W'(2)) && !full)
    else $error("new node written over a sentinel or past the store");

endmodule
